[hdl/qrsp_pkg.sv]
`default_nettype none
package qrsp_pkg;

	// Default sizes of the node and arc stores
	localparam int QRSP_NODE_COUNT = 1024;
	localparam int QRSP_ARC_COUNT  = 4096;

	// Field widths
	localparam int MODE_W   = 2;
	localparam int NODE_W   = 10;
	localparam int COST_W   = 32;
	localparam int DIST_W   = 48;
	localparam int STATUS_W = 2;
	localparam int IN_W     = 56;
	localparam int OUT_W    = 64;

	localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

	// Request kinds
	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR = 2'd0,
		MODE_EDGE  = 2'd1,
		MODE_SOLVE = 2'd2,
		MODE_QUERY = 2'd3
	} mode_t;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_NODE = 2'd2;

	// Per-node solve record
	typedef struct packed {
		logic [DIST_W-1:0] path_dist;
		logic [NODE_W-1:0] pred;
		logic              queued;
	} node_rec_t;

	localparam node_rec_t NODE_REC_INIT = '{path_dist: DIST_INF, pred: '0, queued: 1'b0};

	// Relaxation unit answer
	typedef struct packed {
		logic [DIST_W-1:0] sum;
		logic              better;
	} relax_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_GCLR,
		S_E1, S_E2, S_E3, S_E4,
		S_SCLR, S_SRC, S_POP, S_POPW, S_URD, S_ARC, S_ARCW, S_VRD,
		S_QRD, S_QW, S_RESP
	} st_t;

endpackage
`default_nettype wire

[hdl/qrsp_relax.sv]
`default_nettype none
module qrsp_relax (
	input  wire logic [qrsp_pkg::DIST_W-1:0] dist_u,
	input  wire logic [qrsp_pkg::COST_W-1:0] cost,
	input  wire logic [qrsp_pkg::DIST_W-1:0] dist_v,
	output qrsp_pkg::relax_t                 res
);
	import qrsp_pkg::*;

	logic [DIST_W:0] sum_w;

	// Saturating add, then strict compare against the target distance
	always_comb begin
		sum_w = {1'b0, dist_u} + {{(DIST_W+1-COST_W){1'b0}}, cost};
		if (sum_w >= {1'b0, DIST_INF}) begin
			res.sum = DIST_INF;
		end else begin
			res.sum = sum_w[DIST_W-1:0];
		end
		res.better = dist_v > res.sum;
	end

endmodule
`default_nettype wire

[hdl/queue_relaxed_shortest_path.sv]
`default_nettype none
// Channel  Direction  tdata                                 tuser
// s_*      in         node_a, node_b, cost                  mode
// m_*      out        status, distance, predecessor, reach  -
//
// Clear sweeps every first-arc entry; edge add writes two arcs; query reads one node record.
// Solve clears every node record, then pops nodes and walks their arcs one at a time
// through the one node-record read port and the one relax unit.
// After reset a clearing pass over every node runs before s_tready rises.
// One request at a time; a finished result waits in the output register.
module queue_relaxed_shortest_path #(
	parameter int NODE_COUNT = qrsp_pkg::QRSP_NODE_COUNT,
	parameter int ARC_COUNT  = qrsp_pkg::QRSP_ARC_COUNT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output      logic                       s_tready,
	// node_a[9:0], node_b[19:10], cost[51:20], zero fill
	input  wire logic [qrsp_pkg::IN_W-1:0]  s_tdata,
	// mode[1:0]
	input  wire logic [qrsp_pkg::MODE_W-1:0] s_tuser,
	output      logic                       m_tvalid,
	input  wire logic                       m_tready,
	// status[1:0], distance[49:2], predecessor[59:50], reachable[60], zero fill
	output      logic [qrsp_pkg::OUT_W-1:0] m_tdata
);
	import qrsp_pkg::*;

	localparam int NIW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int AIW = (ARC_COUNT > 1) ? $clog2(ARC_COUNT) : 1;
	localparam int AW  = $clog2(ARC_COUNT + 1);
	localparam int FW  = $clog2(NODE_COUNT + 1);

	function automatic logic node_ok(input logic [NODE_W-1:0] n);
		node_ok = (n != '0) && (32'(n) < NODE_COUNT);
	endfunction

	st_t state_q, state_d;

	// Request fields
	logic [NODE_W-1:0] na_q, nb_q;
	logic [COST_W-1:0] cost_q;

	// Sequencer state
	logic [NIW-1:0]    sw_q;
	logic [AW-1:0]     arc_cnt_q;
	logic [NIW-1:0]    head_q, tail_q;
	logic [FW-1:0]     fill_q;
	logic [NODE_W-1:0] u_q, v_q;
	logic [DIST_W-1:0] du_q;
	logic [COST_W-1:0] c_q;
	logic [AW-1:0]     a_q;

	// Result
	logic [STATUS_W-1:0] res_status_q;
	logic [DIST_W-1:0]   res_dist_q;
	logic [NODE_W-1:0]   res_pred_q;
	logic                res_reach_q;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	// Memories
	logic [AW-1:0]     fa_mem  [NODE_COUNT];
	node_rec_t         nr_mem  [NODE_COUNT];
	logic [NODE_W-1:0] fifo_mem[NODE_COUNT];
	logic [AW-1:0]     an_mem  [ARC_COUNT];
	logic [NODE_W-1:0] at_mem  [ARC_COUNT];
	logic [COST_W-1:0] ac_mem  [ARC_COUNT];

	logic [AW-1:0]     fa_rd_q;
	node_rec_t         nr_rd_q;
	logic [NODE_W-1:0] fifo_rd_q;
	logic [AW-1:0]     an_rd_q;
	logic [NODE_W-1:0] at_rd_q;
	logic [COST_W-1:0] ac_rd_q;

	// Memory controls
	logic              fa_we, nr_we, arc_we, fifo_we;
	logic [NIW-1:0]    fa_wa, fa_ra, nr_wa, nr_ra, fifo_wa;
	logic [AW-1:0]     fa_wd;
	node_rec_t         nr_wd;
	logic [NODE_W-1:0] fifo_wd;
	logic [AIW-1:0]    arc_wa, arc_ra;
	logic [AW-1:0]     arc_wnext;
	logic [NODE_W-1:0] arc_wtgt;

	logic              accept, out_free, sw_last;
	mode_t             in_mode;
	logic [NODE_W-1:0] in_na, in_nb;
	relax_t            rlx;

	assign in_mode  = mode_t'(s_tuser);
	assign in_na    = s_tdata[NODE_W-1:0];
	assign in_nb    = s_tdata[2*NODE_W-1:NODE_W];
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign sw_last  = sw_q == NIW'(NODE_COUNT - 1);
	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	qrsp_relax u_relax (
		.dist_u(du_q),
		.cost  (c_q),
		.dist_v(nr_rd_q.path_dist),
		.res   (rlx)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory controls
	always_comb begin
		state_d   = state_q;
		fa_we     = 1'b0;
		fa_wa     = sw_q;
		fa_wd     = '0;
		fa_ra     = NIW'(na_q);
		nr_we     = 1'b0;
		nr_wa     = sw_q;
		nr_wd     = NODE_REC_INIT;
		nr_ra     = NIW'(na_q);
		arc_we    = 1'b0;
		arc_wa    = AIW'(arc_cnt_q);
		arc_wnext = fa_rd_q;
		arc_wtgt  = nb_q;
		arc_ra    = AIW'(a_q - 1'b1);
		fifo_we   = 1'b0;
		fifo_wa   = tail_q;
		fifo_wd   = v_q;
		case (state_q)
			S_INIT: begin
				fa_we = 1'b1;
				nr_we = 1'b1;
				if (sw_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					case (in_mode)
						MODE_CLEAR: state_d = S_GCLR;
						MODE_EDGE: begin
							if (!node_ok(in_na) || !node_ok(in_nb)) begin
								state_d = S_RESP;
							end else if (arc_cnt_q > AW'(ARC_COUNT - 2)) begin
								state_d = S_RESP;
							end else begin
								state_d = S_E1;
							end
						end
						MODE_SOLVE: state_d = node_ok(in_na) ? S_SCLR : S_RESP;
						MODE_QUERY: state_d = node_ok(in_na) ? S_QRD : S_RESP;
						default: state_d = S_RESP;
					endcase
				end
			end
			S_GCLR: begin
				fa_we = 1'b1;
				if (sw_last) state_d = S_RESP;
			end
			S_E1: begin
				fa_ra   = NIW'(na_q);
				state_d = S_E2;
			end
			S_E2: begin
				arc_we  = 1'b1;
				fa_we   = 1'b1;
				fa_wa   = NIW'(na_q);
				fa_wd   = arc_cnt_q + 1'b1;
				state_d = S_E3;
			end
			S_E3: begin
				fa_ra   = NIW'(nb_q);
				state_d = S_E4;
			end
			S_E4: begin
				arc_we   = 1'b1;
				arc_wtgt = na_q;
				fa_we    = 1'b1;
				fa_wa    = NIW'(nb_q);
				fa_wd    = arc_cnt_q + 1'b1;
				state_d  = S_RESP;
			end
			S_SCLR: begin
				nr_we = 1'b1;
				if (sw_last) state_d = S_SRC;
			end
			S_SRC: begin
				nr_we   = 1'b1;
				nr_wa   = NIW'(na_q);
				nr_wd   = '{path_dist: '0, pred: '0, queued: 1'b1};
				fifo_we = 1'b1;
				fifo_wa = '0;
				fifo_wd = na_q;
				state_d = S_POP;
			end
			S_POP: begin
				state_d = (fill_q == '0) ? S_RESP : S_POPW;
			end
			S_POPW: begin
				nr_ra   = NIW'(fifo_rd_q);
				fa_ra   = NIW'(fifo_rd_q);
				state_d = S_URD;
			end
			S_URD: begin
				nr_we   = 1'b1;
				nr_wa   = NIW'(u_q);
				nr_wd   = '{path_dist: nr_rd_q.path_dist, pred: nr_rd_q.pred, queued: 1'b0};
				state_d = S_ARC;
			end
			S_ARC: begin
				state_d = (a_q == '0) ? S_POP : S_ARCW;
			end
			S_ARCW: begin
				nr_ra   = NIW'(at_rd_q);
				state_d = (32'(at_rd_q) < NODE_COUNT) ? S_VRD : S_ARC;
			end
			S_VRD: begin
				if (rlx.better) begin
					nr_we   = 1'b1;
					nr_wa   = NIW'(v_q);
					nr_wd   = '{path_dist: rlx.sum, pred: u_q, queued: 1'b1};
					fifo_we = !nr_rd_q.queued;
				end
				state_d = S_ARC;
			end
			S_QRD: begin
				nr_ra   = NIW'(na_q);
				state_d = S_QW;
			end
			S_QW: state_d = S_RESP;
			S_RESP: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q       <= '0;
			arc_cnt_q  <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// sweep counter
			if (state_q == S_INIT || state_q == S_GCLR || state_q == S_SCLR) begin
				sw_q <= sw_last ? '0 : sw_q + 1'b1;
			end
			// arc allocation
			if (accept && in_mode == MODE_CLEAR) begin
				arc_cnt_q <= '0;
			end else if (state_q == S_E2 || state_q == S_E4) begin
				arc_cnt_q <= arc_cnt_q + 1'b1;
			end
			// work queue pointers
			if (state_q == S_SRC) begin
				head_q <= '0;
				tail_q <= NIW'(1 % NODE_COUNT);
				fill_q <= FW'(1);
			end else if (state_q == S_POP && fill_q != '0) begin
				head_q <= (head_q == NIW'(NODE_COUNT - 1)) ? '0 : head_q + 1'b1;
				fill_q <= fill_q - 1'b1;
			end else if (fifo_we) begin
				tail_q <= (tail_q == NIW'(NODE_COUNT - 1)) ? '0 : tail_q + 1'b1;
				fill_q <= fill_q + 1'b1;
			end
			// output register
			if (state_q == S_RESP && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			na_q        <= in_na;
			nb_q        <= in_nb;
			cost_q      <= s_tdata[2*NODE_W+COST_W-1:2*NODE_W];
			res_dist_q  <= '0;
			res_pred_q  <= '0;
			res_reach_q <= 1'b0;
			if (in_mode != MODE_CLEAR && !node_ok(in_na)) begin
				res_status_q <= ST_BAD_NODE;
			end else if (in_mode == MODE_EDGE && !node_ok(in_nb)) begin
				res_status_q <= ST_BAD_NODE;
			end else if (in_mode == MODE_EDGE && arc_cnt_q > AW'(ARC_COUNT - 2)) begin
				res_status_q <= ST_FULL;
			end else begin
				res_status_q <= ST_OK;
			end
		end
		if (state_q == S_POPW) u_q <= fifo_rd_q;
		if (state_q == S_URD) begin
			du_q <= nr_rd_q.path_dist;
			a_q  <= fa_rd_q;
		end
		if (state_q == S_ARCW) begin
			v_q <= at_rd_q;
			c_q <= ac_rd_q;
			a_q <= an_rd_q;
		end
		if (state_q == S_QW) begin
			res_dist_q  <= nr_rd_q.path_dist;
			res_reach_q <= nr_rd_q.path_dist != DIST_INF;
			res_pred_q  <= (nr_rd_q.path_dist != DIST_INF) ? nr_rd_q.pred : '0;
		end
		if (state_q == S_RESP && out_free) begin
			m_tdata_q <= {{(OUT_W-STATUS_W-DIST_W-NODE_W-1){1'b0}},
				res_reach_q, res_pred_q, res_dist_q, res_status_q};
		end
	end

	// Node stores
	always_ff @(posedge clk) begin
		if (fa_we) fa_mem[fa_wa] <= fa_wd;
		fa_rd_q <= fa_mem[fa_ra];
		if (nr_we) nr_mem[nr_wa] <= nr_wd;
		nr_rd_q <= nr_mem[nr_ra];
	end

	// Work queue
	always_ff @(posedge clk) begin
		if (fifo_we) fifo_mem[fifo_wa] <= fifo_wd;
		fifo_rd_q <= fifo_mem[head_q];
	end

	// Arc store
	always_ff @(posedge clk) begin
		if (arc_we) begin
			an_mem[arc_wa] <= arc_wnext;
			at_mem[arc_wa] <= arc_wtgt;
			ac_mem[arc_wa] <= cost_q;
		end
		an_rd_q <= an_mem[arc_ra];
		at_rd_q <= at_mem[arc_ra];
		ac_rd_q <= ac_mem[arc_ra];
	end

endmodule
`default_nettype wire

[hdl/qrsp_checker.sv]
`default_nettype none
module qrsp_assert (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_tvalid,
	input wire logic                        s_tready,
	input wire logic                        m_tvalid,
	input wire logic                        m_tready,
	input wire logic [qrsp_pkg::OUT_W-1:0]  m_tdata
);
	import qrsp_pkg::*;

	// A result waiting on the sink is not dropped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// One request at a time: busy right after a request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// Status code is never the unused value
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("unused status code");

	// Unreachable answers carry no predecessor
	a_pred: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[60] |-> m_tdata[59:50] == '0)
		else $error("predecessor without reach");

	// Reachable answers carry a finite distance
	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[60] |-> m_tdata[49:2] != DIST_INF)
		else $error("reachable with infinite distance");

endmodule

bind queue_relaxed_shortest_path qrsp_assert u_qrsp_assert (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire

[tb/qrsp_checker.sv]
`timescale 1ns / 100ps
module qrsp_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	// node_a[9:0], node_b[19:10], cost[51:20], zero fill
	input  wire logic [qrsp_pkg::IN_W-1:0]     s_tdata,
	// mode[1:0]
	input  wire logic [qrsp_pkg::MODE_W-1:0]   s_tuser,
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	// status[1:0], distance[49:2], predecessor[59:50], reachable[60], zero fill
	input  wire logic [qrsp_pkg::OUT_W-1:0]    m_tdata,
	output int                                 fail_count,
	output int                                 open_count
);
	import qrsp_pkg::*;

	localparam int NODES = QRSP_NODE_COUNT;
	localparam int ARCS  = QRSP_ARC_COUNT;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [DIST_W-1:0]   path_dist;
		logic [NODE_W-1:0]   pred;
		logic                reach;
	} answer_t;

	// Graph and solve state of the predictor
	int                unsigned chain_head [NODES];
	int                unsigned chain_next [ARCS];
	logic [NODE_W-1:0] arc_to [ARCS];
	logic [COST_W-1:0] arc_weight [ARCS];
	int                unsigned arcs_used;
	logic [DIST_W-1:0] path_len [NODES];
	logic [NODE_W-1:0] path_from [NODES];
	bit                in_work [NODES];
	int                unsigned work_q [$];
	answer_t           answers_due [$];

	function automatic bit node_valid(logic [NODE_W-1:0] n);
		return n != 0 && int'(n) < NODES;
	endfunction

	function automatic void link_arc(int unsigned from, logic [NODE_W-1:0] to,
			logic [COST_W-1:0] c);
		arc_to[arcs_used]     = to;
		arc_weight[arcs_used] = c;
		chain_next[arcs_used] = chain_head[from];
		chain_head[from]      = arcs_used + 1;
		arcs_used++;
	endfunction

	// Queue-driven relaxation from one source
	function automatic void relax_from(int unsigned src);
		int unsigned u;
		int unsigned a;
		int unsigned v;
		logic [DIST_W:0] sum;
		for (int i = 0; i < NODES; i++) begin
			path_len[i]  = DIST_INF;
			path_from[i] = '0;
			in_work[i]   = 0;
		end
		work_q.delete();
		path_len[src] = '0;
		in_work[src]  = 1;
		work_q = {work_q, src};
		while (work_q.size() != 0) begin
			u = work_q.pop_front();
			in_work[u] = 0;
			a = chain_head[u];
			while (a != 0) begin
				v = arc_to[a-1];
				sum = {1'b0, path_len[u]} + arc_weight[a-1];
				if (sum > {1'b0, DIST_INF})
					sum = {1'b0, DIST_INF};
				if (path_len[v] > sum[DIST_W-1:0]) begin
					path_len[v]  = sum[DIST_W-1:0];
					path_from[v] = u[NODE_W-1:0];
					if (!in_work[v]) begin
						in_work[v] = 1;
						work_q = {work_q, v};
					end
				end
				a = chain_next[a-1];
			end
		end
	endfunction

	function automatic answer_t predict(mode_t md, logic [NODE_W-1:0] na,
			logic [NODE_W-1:0] nb, logic [COST_W-1:0] c);
		answer_t r;
		r = '{status: ST_OK, path_dist: '0, pred: '0, reach: 1'b0};
		case (md)
			MODE_CLEAR: begin
				foreach (chain_head[i]) chain_head[i] = 0;
				arcs_used = 0;
			end
			MODE_EDGE: begin
				if (!node_valid(na) || !node_valid(nb))
					r.status = ST_BAD_NODE;
				else if (ARCS - arcs_used < 2)
					r.status = ST_FULL;
				else begin
					link_arc(na, nb, c);
					link_arc(nb, na, c);
				end
			end
			MODE_SOLVE: begin
				if (!node_valid(na))
					r.status = ST_BAD_NODE;
				else
					relax_from(na);
			end
			default: begin
				if (!node_valid(na))
					r.status = ST_BAD_NODE;
				else begin
					r.path_dist = path_len[na];
					r.reach     = path_len[na] != DIST_INF;
					r.pred      = r.reach ? path_from[na] : '0;
				end
			end
		endcase
		return r;
	endfunction

	assign open_count = answers_due.size();

	// Compare results first, then model the newly accepted request
	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		answer_t got;
		if (!arst_n) begin
			foreach (chain_head[i]) begin
				chain_head[i] = 0;
				path_len[i]   = DIST_INF;
				path_from[i]  = '0;
				in_work[i]    = 0;
			end
			arcs_used = 0;
			work_q.delete();
			answers_due.delete();
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status    = m_tdata[1:0];
				got.path_dist = m_tdata[49:2];
				got.pred      = m_tdata[59:50];
				got.reach     = m_tdata[60];
				if (answers_due.size() == 0) begin
					$error("result with no request outstanding: %h", m_tdata);
					fail_count++;
				end else begin
					want = answers_due.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						fail_count++;
					end
					if (got.path_dist !== want.path_dist) begin
						$error("distance: expected %h, got %h", want.path_dist,
							got.path_dist);
						fail_count++;
					end
					if (got.pred !== want.pred) begin
						$error("predecessor: expected %0d, got %0d", want.pred, got.pred);
						fail_count++;
					end
					if (got.reach !== want.reach) begin
						$error("reachable: expected %0d, got %0d", want.reach, got.reach);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				answers_due = {answers_due, predict(mode_t'(s_tuser), s_tdata[9:0],
					s_tdata[19:10], s_tdata[51:20])};
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
module tb;
	import qrsp_pkg::*;

	localparam longint CYCLE_LIMIT = 40_000_000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_W-1:0]       s_tdata;
	logic [MODE_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;
	int                    fail_count;
	int                    open_count;
	longint                cycles;
	bit                    no_gaps;
	int                    sent_by_mode [4];
	int                    edges_loaded;

	queue_relaxed_shortest_path uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	qrsp_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .open_count(open_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 12);
	endfunction

	// Result side backpressure
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			n = draw_gap();
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	task automatic send_request(mode_t md, logic [NODE_W-1:0] na,
			logic [NODE_W-1:0] nb, logic [COST_W-1:0] c);
		int n;
		n = draw_gap();
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= md;
		s_tdata  <= {4'b0, c, nb, na};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent_by_mode[md]++;
		if (md == MODE_EDGE) edges_loaded++;
		if (md == MODE_CLEAR) edges_loaded = 0;
	endtask

	initial begin
		int span;
		int pick;
		logic [NODE_W-1:0] na;
		logic [NODE_W-1:0] nb;
		logic [COST_W-1:0] c;
		cycles   = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = MODE_CLEAR;
		no_gaps  = 0;
		edges_loaded = 0;
		foreach (sent_by_mode[i]) sent_by_mode[i] = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Directed: query before solve, bad nodes, extremes, ties, self loop, stale
		send_request(MODE_QUERY, 10'd5, 10'd0, 32'd0);
		send_request(MODE_EDGE, 10'd0, 10'd3, 32'd1);
		send_request(MODE_EDGE, 10'd3, 10'd0, 32'd1);
		send_request(MODE_SOLVE, 10'd0, 10'd0, 32'd0);
		send_request(MODE_QUERY, 10'd0, 10'd0, 32'd0);
		send_request(MODE_EDGE, 10'd1, 10'd2, 32'd3);
		send_request(MODE_EDGE, 10'd2, 10'd1023, 32'hFFFF_FFFF);
		send_request(MODE_EDGE, 10'd1, 10'd3, 32'd1);
		send_request(MODE_EDGE, 10'd3, 10'd4, 32'd2);
		send_request(MODE_EDGE, 10'd2, 10'd4, 32'd0);
		send_request(MODE_EDGE, 10'd4, 10'd4, 32'd0);
		send_request(MODE_EDGE, 10'd1023, 10'd1022, 32'hAAAA_5555);
		send_request(MODE_SOLVE, 10'd1, 10'd0, 32'd0);
		send_request(MODE_QUERY, 10'd1, 10'd0, 32'd0);
		send_request(MODE_QUERY, 10'd4, 10'd0, 32'd0);
		send_request(MODE_QUERY, 10'd1023, 10'd0, 32'd0);
		send_request(MODE_QUERY, 10'd1022, 10'd0, 32'd0);
		send_request(MODE_QUERY, 10'd600, 10'd0, 32'd0);
		send_request(MODE_CLEAR, 10'd0, 10'd0, 32'd0);
		send_request(MODE_QUERY, 10'd1023, 10'd0, 32'd0);
		send_request(MODE_SOLVE, 10'd1023, 10'd0, 32'd0);
		send_request(MODE_QUERY, 10'd1, 10'd0, 32'd0);

		// Fill the arc store until it overflows, back to back
		no_gaps = 1;
		for (int i = 0; i < QRSP_ARC_COUNT / 2 + 4; i++)
			send_request(MODE_EDGE, 10'd1000 + 10'($urandom_range(0, 23)),
				10'd1000 + 10'($urandom_range(0, 23)), $urandom);
		no_gaps = 0;
		send_request(MODE_EDGE, 10'd7, 10'd1001, 32'd9);
		send_request(MODE_SOLVE, 10'd7, 10'd0, 32'd0);
		for (int i = 0; i < 6; i++)
			send_request(MODE_QUERY, 10'd1000 + 10'($urandom_range(0, 23)), 10'd0, 32'd0);
		send_request(MODE_CLEAR, 10'd0, 10'd0, 32'd0);

		// Random graphs: mostly small node ranges, occasional full range
		for (int i = 0; i < 1350; i++) begin
			if (i % 150 == 0) begin
				span    = ($urandom_range(0, 4) == 0) ? 1023 : $urandom_range(3, 60);
				no_gaps = $urandom_range(0, 3) == 0;
			end
			pick = $urandom_range(0, 99);
			na = NODE_W'($urandom_range(1, span));
			nb = NODE_W'($urandom_range(1, span));
			c  = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 3)) : $urandom;
			if (pick < 3)
				na = 10'd0;
			if (edges_loaded > 300 || pick == 3)
				send_request(MODE_CLEAR, NODE_W'($urandom), NODE_W'($urandom), $urandom);
			else if (pick < 50)
				send_request(MODE_EDGE, na, (pick == 4) ? 10'd0 : nb, c);
			else if (pick < 62)
				send_request(MODE_SOLVE, na, NODE_W'($urandom), $urandom);
			else
				send_request(MODE_QUERY, na, NODE_W'($urandom), $urandom);
		end
		s_tvalid <= 1'b0;

		while (open_count != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Requests sent: %0d clear, %0d edge, %0d solve, %0d query",
			sent_by_mode[MODE_CLEAR], sent_by_mode[MODE_EDGE],
			sent_by_mode[MODE_SOLVE], sent_by_mode[MODE_QUERY]);
		$display("Covered bad nodes, arc store overflow, self loops, ties and stale reads");
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
